[hdl/obm_pkg.sv]
package obm_pkg;

  // Fixed field geometry
  localparam int COORD_BITS  = 12;
  localparam int SIZE_BITS   = COORD_BITS + 1;
  localparam int END_BITS    = COORD_BITS + 2;
  // Depth of the queue between front and back
  localparam int FRONT_DEPTH = 2;

  typedef struct packed {
    logic [COORD_BITS-1:0] box_left;
    logic [COORD_BITS-1:0] box_top;
    logic [COORD_BITS-1:0] box_width;
    logic [COORD_BITS-1:0] box_height;
    logic                  final_box;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] merged_left;
    logic [COORD_BITS-1:0] merged_top;
    logic [SIZE_BITS-1:0]  merged_width;
    logic [SIZE_BITS-1:0]  merged_height;
    logic                  end_of_list;
    logic                  capacity_lost;
  } out_item_t;

  // One stored merged box
  typedef struct packed {
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] top;
    logic [SIZE_BITS-1:0]  width;
    logic [SIZE_BITS-1:0]  height;
  } box_t;

  // Front to back link
  typedef struct packed {
    logic     valid;
    logic     last;
    in_item_t item;
  } front_link_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_APPEND,
    ST_EMIT_READ,
    ST_EMIT_LOAD
  } eng_state_t;

endpackage

[hdl/obm_front.sv]
module obm_front import obm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_item_t    box,
  output front_link_t link,
  input  logic        take
);

  localparam int PW = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;
  localparam int FW = $clog2(FRONT_DEPTH + 1);

  in_item_t        entries [FRONT_DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [FW-1:0]   fill;
  logic            wr_go;
  logic            rd_go;

  assign full  = (fill == FW'(FRONT_DEPTH));
  assign wr_go = push && !full;
  assign rd_go = take && (fill != '0);

  // Hand the oldest box to the back, tagged as end of set or not
  always_comb begin
    link.valid = (fill != '0);
    link.item  = entries[rptr];
    link.last  = entries[rptr].final_box;
  end

  // Small ring of boxes
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (wr_go) begin
        entries[wptr] <= box;
        wptr          <= (wptr == PW'(FRONT_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd_go) begin
        rptr <= (rptr == PW'(FRONT_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({wr_go, rd_go})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hdl/obm_engine.sv]
module obm_engine import obm_pkg::*; #(
  parameter int MAX_BOXES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  front_link_t link,
  output logic        take,
  output out_item_t   result,
  output logic        result_valid,
  input  logic        result_pop
);

  localparam int IW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int SW = IW + 1;

  eng_state_t      state;
  eng_state_t      state_next;
  logic [IW-1:0]   head;
  logic [CW-1:0]   count;
  logic [CW-1:0]   checked;
  box_t            grow;
  logic            final_set;
  logic            drop;
  box_t            rdata;
  box_t            mem [MAX_BOXES];

  logic            mem_rd;
  logic            mem_wr;
  box_t            wdata;
  logic [SW-1:0]   tail_sum;
  logic [IW-1:0]   tail;
  logic [IW-1:0]   head_inc;
  logic [CW-1:0]   count_m1;
  logic [CW-1:0]   checked_p1;
  logic            last_emit;
  logic            room;
  logic            out_free;

  logic [END_BITS-1:0] f_left, f_top, g_left, g_top;
  logic [END_BITS-1:0] f_right, f_bottom, g_right, g_bottom;
  logic [END_BITS-1:0] max_l, max_t, min_r, min_b, max_r, max_b, min_l, min_t;
  logic                disjoint;
  box_t                uni;

  // Pointer arithmetic on the ring
  assign tail_sum   = SW'(head) + SW'(count);
  assign tail       = (tail_sum >= SW'(MAX_BOXES)) ? IW'(tail_sum - SW'(MAX_BOXES))
                                                   : IW'(tail_sum);
  assign head_inc   = (head == IW'(MAX_BOXES - 1)) ? '0 : head + 1'b1;
  assign count_m1   = count - 1'b1;
  assign checked_p1 = checked + 1'b1;
  assign last_emit  = (checked == count_m1);
  assign room       = (count < CW'(MAX_BOXES));
  assign out_free   = !result_valid || result_pop;

  // Overlap test and bounding union of the front entry and the growing box
  always_comb begin
    f_left   = END_BITS'(rdata.left);
    f_top    = END_BITS'(rdata.top);
    g_left   = END_BITS'(grow.left);
    g_top    = END_BITS'(grow.top);
    f_right  = f_left + END_BITS'(rdata.width);
    f_bottom = f_top + END_BITS'(rdata.height);
    g_right  = g_left + END_BITS'(grow.width);
    g_bottom = g_top + END_BITS'(grow.height);
    max_l    = (f_left > g_left) ? f_left : g_left;
    max_t    = (f_top > g_top) ? f_top : g_top;
    min_l    = (f_left < g_left) ? f_left : g_left;
    min_t    = (f_top < g_top) ? f_top : g_top;
    min_r    = (f_right < g_right) ? f_right : g_right;
    min_b    = (f_bottom < g_bottom) ? f_bottom : g_bottom;
    max_r    = (f_right > g_right) ? f_right : g_right;
    max_b    = (f_bottom > g_bottom) ? f_bottom : g_bottom;
    disjoint = (max_l > min_r) || (max_t > min_b);
    uni.left   = COORD_BITS'(min_l);
    uni.top    = COORD_BITS'(min_t);
    uni.width  = SIZE_BITS'(max_r - min_l);
    uni.height = SIZE_BITS'(max_b - min_t);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (link.valid) begin
          state_next = (count == '0) ? ST_APPEND : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (disjoint) begin
          state_next = (checked_p1 < count) ? ST_READ : ST_APPEND;
        end else begin
          state_next = (count_m1 != '0) ? ST_READ : ST_APPEND;
        end
      end
      ST_APPEND: begin
        state_next = final_set ? ST_EMIT_READ : ST_IDLE;
      end
      ST_EMIT_READ: begin
        state_next = out_free ? ST_EMIT_LOAD : ST_EMIT_READ;
      end
      ST_EMIT_LOAD: begin
        state_next = last_emit ? ST_IDLE : ST_EMIT_READ;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output decode
  always_comb begin
    take   = 1'b0;
    mem_rd = 1'b0;
    mem_wr = 1'b0;
    wdata  = rdata;
    case (state)
      ST_IDLE: begin
        take = link.valid;
      end
      ST_READ: begin
        mem_rd = 1'b1;
      end
      ST_CHECK: begin
        mem_wr = disjoint;
        wdata  = rdata;
      end
      ST_APPEND: begin
        mem_wr = room;
        wdata  = grow;
      end
      ST_EMIT_READ: begin
        mem_rd = out_free;
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  // Merged box store: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[tail] <= wdata;
    end
    if (mem_rd) begin
      rdata <= mem[head];
    end
  end

  // Control and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      head         <= '0;
      count        <= '0;
      checked      <= '0;
      drop         <= 1'b0;
      final_set    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (result_pop) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            grow.left   <= link.item.box_left;
            grow.top    <= link.item.box_top;
            grow.width  <= SIZE_BITS'(link.item.box_width);
            grow.height <= SIZE_BITS'(link.item.box_height);
            final_set   <= link.last;
            checked     <= '0;
          end
        end
        ST_CHECK: begin
          head <= head_inc;
          if (disjoint) begin
            checked <= checked_p1;
          end else begin
            grow    <= uni;
            count   <= count_m1;
            checked <= '0;
          end
        end
        ST_APPEND: begin
          if (room) begin
            count <= count + 1'b1;
          end else begin
            drop <= 1'b1;
          end
          checked <= '0;
        end
        ST_EMIT_LOAD: begin
          result.merged_left   <= rdata.left;
          result.merged_top    <= rdata.top;
          result.merged_width  <= rdata.width;
          result.merged_height <= rdata.height;
          result.end_of_list   <= last_emit;
          result.capacity_lost <= drop;
          result_valid         <= 1'b1;
          head                 <= head_inc;
          checked              <= checked_p1;
          if (last_emit) begin
            count <= '0;
            drop  <= 1'b0;
          end
        end
        default: begin
          head <= head;
        end
      endcase
    end
  end

  // Store never holds more than its depth
  assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_BOXES))
    else $error("merged box count above capacity");

  // A result is only loaded into an empty output register
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_LOAD) |-> !result_valid)
    else $error("output register overwritten");

  // A check always has an entry left to pop
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> (checked < count))
    else $error("check without a pending entry");

  // The end of a list leaves the store empty
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_LOAD && last_emit) |=> (count == '0 && !drop))
    else $error("store not cleared after emission");

endmodule

[hdl/overlapping_box_merger_unit.sv]
// Overlapping box merger.
// Input channel: write a box with push while full is low; final_box marks the
// last box of a set. Result channel: while empty is low the oldest merged box
// is on merged; pop takes it.
// A two-entry queue takes boxes while the merge engine walks the stored list.
// Per box the engine takes it, checks each stored entry with a registered
// store read followed by a compare and rotate, then appends the box if the
// store has room. Each absorbed entry grows the box and restarts the pass.
// On a final box the list is sent front to back, each entry read from the
// store and then loaded into the output register, end_of_list set on the
// last one; the store is then empty again.
// A stalled receiver holds the engine in the sending loop; the input queue
// keeps taking boxes until its two entries are full.
// Reset empties the input queue, the store and the output register; no
// clearing pass is needed.
module overlapping_box_merger_unit import obm_pkg::*; #(
  parameter int MAX_BOXES = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  box,
  output logic      empty,
  input  logic      pop,
  output out_item_t merged
);

  front_link_t link;
  logic        take;
  logic        result_valid;
  logic        result_pop;

  assign empty      = !result_valid;
  assign result_pop = pop && result_valid;

  // Input side
  obm_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .box  (box),
    .link (link),
    .take (take)
  );

  // Merge and emission side
  obm_engine #(
    .MAX_BOXES (MAX_BOXES)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .link         (link),
    .take         (take),
    .result       (merged),
    .result_valid (result_valid),
    .result_pop   (result_pop)
  );

endmodule

[verif/merge_checker.sv]
`timescale 1ns / 1ps
module merge_checker import obm_pkg::*; #(
  parameter int MAX_BOXES = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  in_item_t  box,
  input  logic      empty,
  input  logic      pop,
  input  out_item_t merged,
  output int        errors,
  output int        pending
);

  // Predicted list of merged boxes, front at index 0
  box_t      merged_list[$];
  // Boxes the block still owes us, oldest first
  out_item_t expected_boxes[$];
  bit        set_dropped;
  int        fail_count;
  int        outstanding;
  out_item_t want;

  assign errors  = fail_count;
  assign pending = outstanding;

  // Merge one incoming box into the list; on the last box of a set, queue
  // the whole list as expected output and clear it.
  task automatic fold_box(input in_item_t b);
    box_t        grow;
    box_t        front;
    out_item_t   r;
    int          checked;
    int unsigned fr;
    int unsigned fb;
    int unsigned gr;
    int unsigned gb;
    int unsigned lo;
    int unsigned hi;
    grow.left   = b.box_left;
    grow.top    = b.box_top;
    grow.width  = SIZE_BITS'(b.box_width);
    grow.height = SIZE_BITS'(b.box_height);
    checked = 0;
    while (checked < merged_list.size()) begin
      front = merged_list[0];
      merged_list.delete(0);
      fr = front.left + front.width;
      fb = front.top + front.height;
      gr = grow.left + grow.width;
      gb = grow.top + grow.height;
      // closed extents: touching edges count as overlap
      if ((front.left > grow.left ? front.left : grow.left) > (fr < gr ? fr : gr) ||
          (front.top > grow.top ? front.top : grow.top) > (fb < gb ? fb : gb)) begin
        merged_list = {merged_list, front};
        checked++;
      end else begin
        // absorb into the bounding union and start the pass over
        lo = front.left < grow.left ? front.left : grow.left;
        hi = fr > gr ? fr : gr;
        grow.left  = COORD_BITS'(lo);
        grow.width = SIZE_BITS'(hi - lo);
        lo = front.top < grow.top ? front.top : grow.top;
        hi = fb > gb ? fb : gb;
        grow.top    = COORD_BITS'(lo);
        grow.height = SIZE_BITS'(hi - lo);
        checked = 0;
      end
    end
    if (merged_list.size() < MAX_BOXES) begin
      merged_list = {merged_list, grow};
    end else begin
      set_dropped = 1'b1;
    end
    if (b.final_box) begin
      foreach (merged_list[i]) begin
        r.merged_left   = merged_list[i].left;
        r.merged_top    = merged_list[i].top;
        r.merged_width  = merged_list[i].width;
        r.merged_height = merged_list[i].height;
        r.end_of_list   = (i == merged_list.size() - 1);
        r.capacity_lost = set_dropped;
        expected_boxes = {expected_boxes, r};
      end
      merged_list.delete();
      set_dropped = 1'b0;
    end
  endtask

  // Watch both channels; compare each popped box with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      merged_list.delete();
      expected_boxes.delete();
      set_dropped = 1'b0;
      fail_count  = 0;
    end else begin
      if (push && !full) begin
        fold_box(box);
      end
      if (pop && !empty) begin
        if (expected_boxes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected merged box, expected none, got l=%0d t=%0d w=%0d h=%0d",
                   $time, merged.merged_left, merged.merged_top, merged.merged_width,
                   merged.merged_height);
        end else begin
          want = expected_boxes[0];
          expected_boxes.delete(0);
          if (merged.merged_left !== want.merged_left ||
              merged.merged_top !== want.merged_top ||
              merged.merged_width !== want.merged_width ||
              merged.merged_height !== want.merged_height ||
              merged.end_of_list !== want.end_of_list ||
              merged.capacity_lost !== want.capacity_lost) begin
            fail_count++;
            $display("%0t: merged box mismatch, expected l=%0d t=%0d w=%0d h=%0d eol=%b lost=%b",
                     $time, want.merged_left, want.merged_top, want.merged_width,
                     want.merged_height, want.end_of_list, want.capacity_lost);
            $display("%0t:                      actual   l=%0d t=%0d w=%0d h=%0d eol=%b lost=%b",
                     $time, merged.merged_left, merged.merged_top, merged.merged_width,
                     merged.merged_height, merged.end_of_list, merged.capacity_lost);
          end
        end
      end
    end
    outstanding = expected_boxes.size();
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import obm_pkg::*;

  localparam int MAX_BOXES    = 32;
  localparam int ITEM_TARGET  = 420;
  localparam int QUIET_ITEMS  = 60;
  // worst single pass over a full list plus margin
  localparam int FLUSH_CYCLES = 2 * MAX_BOXES + 40;

  typedef enum {
    SET_CLUSTER,
    SET_GRID,
    SET_WILD
  } set_kind_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  box;
  logic      empty;
  logic      pop;
  out_item_t merged;
  int        errors;
  int        pending;

  int        sent_count;
  int        gap_pct;
  int        stall_pct;
  int        set_no;
  set_kind_t kind;

  always #4 clk = ~clk;

  overlapping_box_merger_unit #(.MAX_BOXES(MAX_BOXES)) u_top (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .box    (box),
    .empty  (empty),
    .pop    (pop),
    .merged (merged)
  );

  merge_checker #(.MAX_BOXES(MAX_BOXES)) u_checker (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .box     (box),
    .empty   (empty),
    .pop     (pop),
    .merged  (merged),
    .errors  (errors),
    .pending (pending)
  );

  function automatic in_item_t make_box(input int l, input int t, input int w, input int h,
                                        input bit last);
    in_item_t b;
    b.box_left   = COORD_BITS'(l);
    b.box_top    = COORD_BITS'(t);
    b.box_width  = COORD_BITS'(w);
    b.box_height = COORD_BITS'(h);
    b.final_box  = last;
    return b;
  endfunction

  // One input transaction, with an optional idle burst ahead of it
  task automatic send_box(input in_item_t b);
    if ($urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    push <= 1'b1;
    box  <= b;
    do @(posedge clk); while (full);
    sent_count++;
  endtask

  // Boxes scattered around one spot: lots of merging and restarts
  task automatic send_cluster_set();
    int n;
    int cx;
    int cy;
    int spread;
    int l;
    int t;
    n      = $urandom_range(1, 12);
    cx     = $urandom_range(0, 4095);
    cy     = $urandom_range(0, 4095);
    spread = $urandom_range(0, 400);
    for (int i = 0; i < n; i++) begin
      l = cx + $urandom_range(0, spread);
      t = cy + $urandom_range(0, spread);
      send_box(make_box(l > 4095 ? 4095 : l, t > 4095 ? 4095 : t,
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                    : $urandom_range(0, 80),
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                    : $urandom_range(0, 80),
                        i == n - 1));
    end
  endtask

  // Separated boxes on an 8x8 grid: long lists, store overflow; optional
  // wide boxes that bridge neighboring cells
  task automatic send_grid_set();
    int n;
    int start;
    int k;
    int w;
    int h;
    bit bridging;
    n        = $urandom_range(20, 40);
    start    = $urandom_range(0, 63);
    bridging = $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      k = (start + i) % 64;
      if (bridging && $urandom_range(0, 3) == 0) begin
        w = $urandom_range(500, 1500);
        h = $urandom_range(500, 1500);
      end else begin
        w = $urandom_range(0, 300);
        h = $urandom_range(0, 300);
      end
      send_box(make_box((k % 8) * 512 + $urandom_range(0, 100),
                        (k / 8) * 512 + $urandom_range(0, 100), w, h, i == n - 1));
    end
  endtask

  // Fully random boxes over the whole field range
  task automatic send_wild_set();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      send_box(make_box($urandom, $urandom, $urandom, $urandom, i == n - 1));
    end
  endtask

  // Result side: pop held high except for random stall bursts
  initial begin
    pop = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if ($urandom_range(0, 99) < stall_pct) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    rst        = 1'b1;
    push       = 1'b0;
    box        = '0;
    sent_count = 0;
    gap_pct    = 10;
    stall_pct  = 10;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // field extremes
    send_box(make_box(0, 0, 0, 0, 1'b1));
    send_box(make_box(4095, 4095, 4095, 4095, 1'b1));
    // far corners touching at one point, union grows past 12 bits
    send_box(make_box(4095, 4095, 4095, 4095, 1'b0));
    send_box(make_box(0, 0, 4095, 4095, 1'b1));
    // thin strips crossing at the corner
    send_box(make_box(0, 4095, 4095, 0, 1'b0));
    send_box(make_box(4095, 0, 0, 4095, 1'b1));
    // three disjoint boxes emitted in order
    send_box(make_box(0, 0, 0, 0, 1'b0));
    send_box(make_box(4095, 4095, 4095, 4095, 1'b0));
    send_box(make_box(1, 1, 0, 0, 1'b1));
    // shared edge merges, one-pixel gap does not
    send_box(make_box(100, 100, 50, 50, 1'b0));
    send_box(make_box(150, 100, 10, 10, 1'b0));
    send_box(make_box(100, 151, 10, 10, 1'b1));
    // zero-size points: same spot merges, neighbor stays apart
    send_box(make_box(10, 10, 0, 0, 1'b0));
    send_box(make_box(10, 10, 0, 0, 1'b0));
    send_box(make_box(11, 10, 0, 0, 1'b1));
    // growth after one absorb reaches an entry checked earlier in the pass
    send_box(make_box(0, 10, 10, 10, 1'b0));
    send_box(make_box(50, 0, 10, 10, 1'b0));
    send_box(make_box(5, 0, 50, 2, 1'b1));
    // one box swallows a whole row
    send_box(make_box(0, 0, 10, 10, 1'b0));
    send_box(make_box(100, 0, 10, 10, 1'b0));
    send_box(make_box(200, 0, 10, 10, 1'b0));
    send_box(make_box(5, 0, 200, 5, 1'b1));

    // random sets; two grid sets first, each of which may overflow the store
    set_no = 0;
    while (sent_count < ITEM_TARGET) begin
      if (sent_count >= ITEM_TARGET - QUIET_ITEMS) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 40;
        endcase
      end
      if (set_no < 2) begin
        kind = SET_GRID;
      end else begin
        case ($urandom_range(0, 5))
          0, 1, 2: kind = SET_CLUSTER;
          3: kind = SET_GRID;
          default: kind = SET_WILD;
        endcase
      end
      case (kind)
        SET_CLUSTER: send_cluster_set();
        SET_GRID: send_grid_set();
        default: send_wild_set();
      endcase
      set_no++;
    end
    push <= 1'b0;

    // let the checker see the last transaction before draining
    @(posedge clk);
    // drain, then give the block time to show anything extra
    while (pending != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("** overlapping_box_merger_unit: PASSED **");
    end else begin
      $display("** overlapping_box_merger_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #32_000_000;
    $display("** overlapping_box_merger_unit: FAILED **");
    $finish;
  end

endmodule

[files.f]
hdl/obm_pkg.sv
hdl/obm_front.sv
hdl/obm_engine.sv
hdl/overlapping_box_merger_unit.sv
verif/merge_checker.sv
verif/tb_top.sv
